FILE: rtl/eqpan_pkg.sv
// Shared types, constants and fixed-point helpers of the equal-power stereo pan ramp.
`default_nettype none

package eqpan_pkg;

  // Fixed-point constants, Q16 unless noted.
  localparam logic [16:0]        ONE_Q16    = 17'd65536;
  localparam logic [16:0]        PAN_RESET  = 17'd32768;
  localparam logic [15:0]        SCALE_MAG  = 16'd54513;
  localparam logic [17:0]        INNER_BASE = 18'd120049;   // 1.0 + SCALE_MAG
  localparam logic [15:0]        SMOOTH_Q16 = 16'd58982;    // 0.9
  localparam logic [20:0]        THRESH_Q16 = 21'd131;      // 0.002
  localparam logic signed [19:0] GAIN_RESET = 20'sd46396;   // law of the reset position

  localparam int RAMP_LEN_DEF = 64;
  localparam int MAX_BLOCK    = 4096;

  // Restoring divider for the ramp step: one quotient bit per cycle.
  localparam int DIV_W     = 21;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Configuration register indexes.
  localparam logic REG_PAN   = 1'b0;
  localparam logic REG_MUTED = 1'b1;

  // Channel select.
  localparam logic CH_LEFT  = 1'b0;
  localparam logic CH_RIGHT = 1'b1;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_TGT_M1,
    OP_TGT_M2,
    OP_TGT_WR,
    OP_START,
    OP_DIV,
    OP_DIV_WR,
    OP_BLK_END,
    OP_RMP_BASE,
    OP_RMP_MUL,
    OP_RMP_WR,
    OP_RMP_CNT,
    OP_MIX1,
    OP_MIX2,
    OP_MIX3,
    OP_MIX4,
    OP_MIX5,
    OP_PASS,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic chan;
  } cmd_t;

  typedef struct packed {
    logic muted;
    logic block_start;
    logic need_div;
    logic div_last;
    logic ramp_go;
    logic act_left;
    logic act_right;
    logic out_free;
  } sts_t;

  // Round a Q16 product to nearest, halves away from zero.
  function automatic logic signed [33:0] rnd16(input logic signed [49:0] p);
    logic [49:0] mag;
    logic [49:0] sum;
    logic [33:0] r;
    mag = p[49] ? $unsigned(-p) : $unsigned(p);
    sum = mag + 50'd32768;
    r   = sum[49:16];
    return p[49] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [19:0] sat20(input logic signed [35:0] v);
    if (v > 36'sd524287) begin
      return 20'sh7FFFF;
    end else if (v < -36'sd524288) begin
      return 20'sh80000;
    end
    return v[19:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [35:0] v);
    if (v > 36'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -36'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/eqpan_ctrl.sv
// Sequencing state machine of the equal-power stereo pan ramp.
`default_nettype none

module eqpan_ctrl
  import eqpan_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  sts_t      sts,
  output cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_TGT1,
    S_TGT2,
    S_TGT3,
    S_START,
    S_DIV,
    S_DIVWR,
    S_BLKEND,
    S_RCHK,
    S_RBASE,
    S_RMUL,
    S_RWR,
    S_RCNT,
    S_MIX1,
    S_MIX2,
    S_MIX3,
    S_MIX4,
    S_MIX5,
    S_PASS,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   chan_r, chan_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    chan_nxt  = chan_r;
    cmd.op    = OP_IDLE;
    cmd.chan  = chan_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.muted) begin
          state_nxt = S_PASS;
        end else if (sts.block_start) begin
          chan_nxt  = CH_LEFT;
          state_nxt = S_TGT1;
        end else begin
          state_nxt = S_RCHK;
        end
      end
      S_TGT1: begin
        cmd.op    = OP_TGT_M1;
        state_nxt = S_TGT2;
      end
      S_TGT2: begin
        cmd.op    = OP_TGT_M2;
        state_nxt = S_TGT3;
      end
      S_TGT3: begin
        cmd.op    = OP_TGT_WR;
        state_nxt = S_START;
      end
      S_START: begin
        cmd.op = OP_START;
        if (sts.need_div) begin
          state_nxt = S_DIV;
        end else if (chan_r == CH_LEFT) begin
          chan_nxt  = CH_RIGHT;
          state_nxt = S_TGT1;
        end else begin
          state_nxt = S_BLKEND;
        end
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (sts.div_last) begin
          state_nxt = S_DIVWR;
        end
      end
      S_DIVWR: begin
        cmd.op = OP_DIV_WR;
        if (chan_r == CH_LEFT) begin
          chan_nxt  = CH_RIGHT;
          state_nxt = S_TGT1;
        end else begin
          state_nxt = S_BLKEND;
        end
      end
      S_BLKEND: begin
        cmd.op    = OP_BLK_END;
        state_nxt = S_RCHK;
      end
      S_RCHK: begin
        if (sts.ramp_go) begin
          chan_nxt  = sts.act_left ? CH_LEFT : CH_RIGHT;
          state_nxt = S_RBASE;
        end else begin
          state_nxt = S_MIX1;
        end
      end
      S_RBASE: begin
        cmd.op    = OP_RMP_BASE;
        state_nxt = S_RMUL;
      end
      S_RMUL: begin
        cmd.op    = OP_RMP_MUL;
        state_nxt = S_RWR;
      end
      S_RWR: begin
        cmd.op = OP_RMP_WR;
        if (chan_r == CH_LEFT && sts.act_right) begin
          chan_nxt  = CH_RIGHT;
          state_nxt = S_RBASE;
        end else begin
          state_nxt = S_RCNT;
        end
      end
      S_RCNT: begin
        cmd.op    = OP_RMP_CNT;
        state_nxt = S_MIX1;
      end
      S_MIX1: begin
        cmd.op    = OP_MIX1;
        state_nxt = S_MIX2;
      end
      S_MIX2: begin
        cmd.op    = OP_MIX2;
        state_nxt = S_MIX3;
      end
      S_MIX3: begin
        cmd.op    = OP_MIX3;
        state_nxt = S_MIX4;
      end
      S_MIX4: begin
        cmd.op    = OP_MIX4;
        state_nxt = S_MIX5;
      end
      S_MIX5: begin
        cmd.op    = OP_MIX5;
        state_nxt = S_EMIT;
      end
      S_PASS: begin
        cmd.op    = OP_PASS;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // Wait here until the output register can take the new result.
        if (sts.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      chan_r  <= CH_LEFT;
    end else begin
      state_r <= state_nxt;
      chan_r  <= chan_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/eqpan_dp.sv
// Datapath of the equal-power stereo pan ramp: shared multiplier, divider and state.
`default_nettype none

module eqpan_dp
  import eqpan_pkg::*;
#(
  parameter int RAMP_LEN = RAMP_LEN_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  wire logic signed [23:0] in_sample,
  input  wire logic signed [23:0] in_left_accum,
  input  wire logic signed [23:0] in_right_accum,
  input  wire logic [17:0]        in_gain,
  input  wire logic               in_block_start,
  input  wire logic [12:0]        in_block_length,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_index,
  input  wire logic [16:0]        cfg_data,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output logic signed [23:0]      out_left_mix,
  output logic signed [23:0]      out_right_mix
);

  localparam int LIM_W   = $clog2(RAMP_LEN + 1);
  localparam int LIM_CAP = (RAMP_LEN < MAX_BLOCK) ? RAMP_LEN : MAX_BLOCK;

  // Configuration and control state.
  logic [16:0]        pan_r;
  logic               muted_r;
  logic signed [19:0] gl_r, gr_r, bl_r, br_r, sl_r, sr_r;
  logic               al_r, ar_r;
  logic [LIM_W-1:0]   fc_r, rf_r;
  logic               out_valid_r;

  // Payload and working registers.
  logic signed [23:0]   s_r, la_r, ra_r;
  logic [17:0]          gc_r;
  logic                 bs_r;
  logic [LIM_W-1:0]     lim_r;
  logic signed [49:0]   mul_r;
  logic [16:0]          tgt_r;
  logic [DIV_W-1:0]     dq_r;
  logic [LIM_W-1:0]     rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic                 neg_r;
  logic signed [22:0]   pan_l_r, pan_rt_r;
  logic signed [23:0]   lm_r, rm_r, olm_r, orm_r;

  // Combinational helpers.
  logic signed [19:0] g_ch, b_ch, st_ch;
  logic [16:0]        q_pos;
  logic signed [33:0] mul_rnd;
  logic [17:0]        inner;
  logic signed [20:0] dlt;
  logic [20:0]        mag;
  logic signed [20:0] gb_diff;
  logic signed [19:0] base_sum;
  logic signed [19:0] gain_new;
  logic signed [35:0] quo_ext;
  logic signed [19:0] step_new;
  logic [LIM_W:0]     rem_sh;
  logic               qbit;
  logic [LIM_W-1:0]   fc_inc;
  logic [LIM_W-1:0]   lim_nxt;
  logic [16:0]        pan_nxt;
  logic signed [24:0] ma, mb;
  logic               out_free;

  always_comb begin
    g_ch  = cmd.chan ? gr_r : gl_r;
    b_ch  = cmd.chan ? br_r : bl_r;
    st_ch = cmd.chan ? sr_r : sl_r;
    q_pos = cmd.chan ? pan_r : (ONE_Q16 - pan_r);

    mul_rnd = rnd16(mul_r);
    inner   = INNER_BASE - mul_rnd[17:0];

    dlt = {g_ch[19], g_ch} - $signed({4'b0, tgt_r});
    mag = dlt[20] ? $unsigned(-dlt) : $unsigned(dlt);

    gb_diff  = {g_ch[19], g_ch} - {b_ch[19], b_ch};
    base_sum = sat20(36'({{16{b_ch[19]}}, b_ch}) + 36'({{16{st_ch[19]}}, st_ch}));
    gain_new = sat20(36'({{16{b_ch[19]}}, b_ch}) + 36'({{2{mul_rnd[33]}}, mul_rnd}));
    quo_ext  = $signed({15'b0, dq_r});
    step_new = sat20(neg_r ? quo_ext : -quo_ext);

    rem_sh = {rem_r, dq_r[DIV_W-1]};
    qbit   = (rem_sh >= {1'b0, lim_r});
    fc_inc = fc_r + LIM_W'(1);

    if (in_block_length == 13'd0) begin
      lim_nxt = LIM_W'(1);
    end else if ({4'b0, in_block_length} > 17'(LIM_CAP)) begin
      lim_nxt = LIM_W'(LIM_CAP);
    end else begin
      lim_nxt = in_block_length[LIM_W-1:0];
    end

    pan_nxt = (cfg_data > ONE_Q16) ? ONE_Q16 : cfg_data;

    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_TGT_M1: begin
        ma = $signed({9'b0, SCALE_MAG});
        mb = $signed({8'b0, q_pos});
      end
      OP_TGT_M2: begin
        ma = $signed({8'b0, q_pos});
        mb = $signed({7'b0, inner});
      end
      OP_RMP_MUL: begin
        ma = $signed({9'b0, SMOOTH_Q16});
        mb = {{4{gb_diff[20]}}, gb_diff};
      end
      OP_MIX1: begin
        ma = {{5{gl_r[19]}}, gl_r};
        mb = $signed({7'b0, gc_r});
      end
      OP_MIX2: begin
        ma = {{5{gr_r[19]}}, gr_r};
        mb = $signed({7'b0, gc_r});
      end
      OP_MIX3: begin
        ma = {s_r[23], s_r};
        mb = {{2{pan_l_r[22]}}, pan_l_r};
      end
      OP_MIX4: begin
        ma = {s_r[23], s_r};
        mb = {{2{pan_rt_r[22]}}, pan_rt_r};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase

    out_free = !out_valid_r || !out_stall;
  end

  assign sts.muted       = muted_r;
  assign sts.block_start = bs_r;
  assign sts.need_div    = (mag > THRESH_Q16);
  assign sts.div_last    = (div_cnt_r == DIV_CNT_W'(DIV_W - 1));
  assign sts.ramp_go     = (al_r || ar_r) && (fc_r < rf_r);
  assign sts.act_left    = al_r;
  assign sts.act_right   = ar_r;
  assign sts.out_free    = out_free;

  assign out_valid     = out_valid_r;
  assign out_left_mix  = olm_r;
  assign out_right_mix = orm_r;

  // Registers that reset clears.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pan_r       <= PAN_RESET;
      muted_r     <= 1'b0;
      gl_r        <= GAIN_RESET;
      gr_r        <= GAIN_RESET;
      bl_r        <= GAIN_RESET;
      br_r        <= GAIN_RESET;
      sl_r        <= '0;
      sr_r        <= '0;
      al_r        <= 1'b0;
      ar_r        <= 1'b0;
      fc_r        <= '0;
      rf_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_PAN:   pan_r   <= pan_nxt;
          REG_MUTED: muted_r <= cfg_data[0];
          default:   ;
        endcase
      end
      if (out_valid_r && !out_stall && cmd.op != OP_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        OP_START: begin
          if (mag > THRESH_Q16) begin
            if (cmd.chan) ar_r <= 1'b1;
            else          al_r <= 1'b1;
          end else if (cmd.chan) begin
            gr_r <= $signed({3'b0, tgt_r});
            br_r <= $signed({3'b0, tgt_r});
            sr_r <= '0;
            ar_r <= 1'b0;
          end else begin
            gl_r <= $signed({3'b0, tgt_r});
            bl_r <= $signed({3'b0, tgt_r});
            sl_r <= '0;
            al_r <= 1'b0;
          end
        end
        OP_DIV_WR: begin
          if (cmd.chan) sr_r <= step_new;
          else          sl_r <= step_new;
        end
        OP_BLK_END: begin
          fc_r <= '0;
          rf_r <= lim_r;
        end
        OP_RMP_BASE: begin
          if (cmd.chan) br_r <= base_sum;
          else          bl_r <= base_sum;
        end
        OP_RMP_WR: begin
          if (cmd.chan) gr_r <= gain_new;
          else          gl_r <= gain_new;
        end
        OP_RMP_CNT: begin
          fc_r <= fc_inc;
          if (fc_inc >= rf_r) begin
            al_r <= 1'b0;
            ar_r <= 1'b0;
          end
        end
        OP_EMIT: begin
          out_valid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Payload and working registers, no reset needed.
  always_ff @(posedge clk) begin
    mul_r <= ma * mb;
    unique case (cmd.op)
      OP_LOAD: begin
        s_r   <= in_sample;
        la_r  <= in_left_accum;
        ra_r  <= in_right_accum;
        gc_r  <= in_gain;
        bs_r  <= in_block_start;
        lim_r <= lim_nxt;
      end
      OP_TGT_WR: begin
        tgt_r <= mul_rnd[16:0];
      end
      OP_START: begin
        neg_r     <= dlt[20];
        dq_r      <= mag;
        rem_r     <= '0;
        div_cnt_r <= '0;
      end
      OP_DIV: begin
        rem_r     <= qbit ? LIM_W'(rem_sh - {1'b0, lim_r}) : rem_sh[LIM_W-1:0];
        dq_r      <= {dq_r[DIV_W-2:0], qbit};
        div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      end
      OP_MIX2: begin
        pan_l_r <= mul_rnd[22:0];
      end
      OP_MIX3: begin
        pan_rt_r <= mul_rnd[22:0];
      end
      OP_MIX4: begin
        lm_r <= sat24(36'({{12{la_r[23]}}, la_r}) + 36'({{2{mul_rnd[33]}}, mul_rnd}));
      end
      OP_MIX5: begin
        rm_r <= sat24(36'({{12{ra_r[23]}}, ra_r}) + 36'({{2{mul_rnd[33]}}, mul_rnd}));
      end
      OP_PASS: begin
        lm_r <= la_r;
        rm_r <= ra_r;
      end
      OP_EMIT: begin
        olm_r <= lm_r;
        orm_r <= rm_r;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/equal_power_stereo_pan_ramp.sv
// Top level of the equal-power stereo pan ramp: controller, datapath and ports.
// A plain sample runs the mix; a muted one passes its mix values through. A ramp sample first
// updates base and gain of each ramping channel, and a block start first finds each channel's
// target and, for a channel that starts a ramp, its step by a divider that gives one bit per
// cycle. A new transaction is taken only after the last result is in the output register; all
// products go through one shared 25x25 multiplier. Reset is synchronous, active low.
`default_nettype none

module equal_power_stereo_pan_ramp
  import eqpan_pkg::*;
#(
  parameter int RAMP_LEN = RAMP_LEN_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Input channel: one mono sample and the mix values it adds into.
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [23:0] in_sample,
  input  wire logic signed [23:0] in_left_accum,
  input  wire logic signed [23:0] in_right_accum,
  input  wire logic [17:0]        in_gain,
  input  wire logic               in_block_start,
  input  wire logic [12:0]        in_block_length,
  // Result channel.
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [23:0]      out_left_mix,
  output logic signed [23:0]      out_right_mix,
  // Configuration write channel.
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [16:0]        cfg_data
);

  // The controller walks each transaction through a sequence of datapath operations
  // chosen by the status flags. A block start computes each channel's equal-power
  // target with the shared multiplier, then decides for that channel whether to snap or
  // to ramp; a ramp step is found by a restoring divider, one quotient bit per cycle.
  // While a ramp is running, each active channel updates its linear base and smoothed
  // gain before the mix. The mix itself interleaves left and right through the multiplier.
  //
  // The finished result sits in an output register, so the next input transaction is
  // taken while a result still waits on a stalled output. Configuration writes are
  // always accepted; they are expected only while the block is idle.

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  eqpan_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  eqpan_dp #(
    .RAMP_LEN (RAMP_LEN)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_sample       (in_sample),
    .in_left_accum   (in_left_accum),
    .in_right_accum  (in_right_accum),
    .in_gain         (in_gain),
    .in_block_start  (in_block_start),
    .in_block_length (in_block_length),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_left_mix    (out_left_mix),
    .out_right_mix   (out_right_mix)
  );

endmodule

`default_nettype wire
